@@ design/slr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_pkg
// Shared constants and types of the serial line receiver: store depth, item
// and event codes, register indexes and the staged result record.
// ----------------------------------------------------------------------------
package slr_pkg;

    // Line store geometry
    localparam int LINE_DEPTH = 512;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    // Field widths fixed by the interface
    localparam int LEN_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 9;
    localparam int CFG_W   = 10;
    localparam int IDLE_W  = 10;

    // Character codes
    localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;

    // Length prefix size and idle counter ceiling
    localparam logic [LEN_W-1:0]  PREFIX_BYTES = 10'd4;
    localparam logic [IDLE_W-1:0] IDLE_MAX     = 10'd1023;

    // Register reset values
    localparam logic [CFG_W-1:0] MAX_LINE_RST   = 10'd512;
    localparam logic [CFG_W-1:0] IDLE_FLUSH_RST = 10'd50;

    // Register indexes
    localparam logic CFG_MAX_LINE   = 1'b0;
    localparam logic CFG_IDLE_FLUSH = 1'b1;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // Result event codes
    typedef enum logic [1:0] {
        EV_COMPLETE = 2'd0,
        EV_DROP     = 2'd1,
        EV_FLUSH    = 2'd2,
        EV_READ     = 2'd3
    } t_event;

    // Result record waiting for the store read data
    typedef struct packed {
        t_event           ev;
        logic [LEN_W-1:0] len;
        logic             flag;
        logic             rd_ok;
    } t_stage;

endpackage : slr_pkg
`default_nettype wire

@@ design/serial_line_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_receiver
// Newline-delimited line framer with idle flush, length prefix detection and
// read-back of the stored line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transfer:
//   a received byte, a millisecond tick, or a read of one stored byte.
//   Output channel (o_out_valid / i_out_ready) carries at most one result per
//   item: line complete, oversized line dropped, idle flush, or read data.
//   Line state is updated in the cycle an item is transferred, so one item
//   can be taken every cycle while o_in_ready is high. A result passes the
//   staging register, beside the registered store read, then the output register.
//   A staging register sits in front of the output register, so input keeps
//   flowing while a result waits; only when both are full and the receiver
//   holds i_out_ready low does o_in_ready drop.
//   Reset (i_rst_n low, synchronous) empties both result registers, clears
//   the line length, discard flag, prefix word and idle count, and loads the
//   register defaults (max line 512, idle flush 50). The line store itself is
//   not cleared; reading an entry never written returns an undefined byte.
//   Configuration writes (i_cfg_we) take effect at the next edge and are
//   expected only while no item is in flight.
// ----------------------------------------------------------------------------
module serial_line_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [slr_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [slr_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [slr_pkg::RIDX_W-1:0]  i_read_index,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_event_res,
    output logic [slr_pkg::LEN_W-1:0]        o_payload_length,
    output logic                             o_had_length_prefix,
    output logic [slr_pkg::BYTE_W-1:0]       o_read_byte
);

    import slr_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]  r_max_line;
    logic [CFG_W-1:0]  r_idle_flush;

    // Line state
    logic [LEN_W-1:0]  r_len,     n_len;
    logic              r_discard, n_discard;
    logic [31:0]       r_prefix,  n_prefix;
    logic [IDLE_W-1:0] r_idle,    n_idle;

    // Staging and output registers
    logic              r_s1_valid;
    t_stage            r_s1;
    logic              r_out_valid;
    t_event            r_out_ev;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_flag;
    logic [BYTE_W-1:0] r_out_byte;

    // Combinational results
    logic              in_fire;
    logic              s1_adv;
    logic              res_valid;
    t_stage            res;
    logic              wr_en;
    logic              rd_en;
    logic [LEN_W-1:0]  limit;
    logic [IDLE_W-1:0] idle_thr;
    logic              pfx_hit;
    logic [LEN_W-1:0]  pfx_len;
    logic              rd_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_kind             kind;

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign kind       = t_kind'(i_kind);

    // Effective limits
    assign limit    = (32'(r_max_line) > 32'(LINE_DEPTH)) ? LEN_W'(LINE_DEPTH) : r_max_line;
    assign idle_thr = (r_idle_flush == '0) ? IDLE_W'(1) : r_idle_flush;

    // Length prefix check on the current line
    assign pfx_hit = (r_len >= PREFIX_BYTES) && (r_prefix == 32'(r_len - PREFIX_BYTES));
    assign pfx_len = pfx_hit ? (r_len - PREFIX_BYTES) : r_len;

    // Store addressing
    assign rd_ok   = 32'(i_read_index) < 32'(LINE_DEPTH);
    assign wr_addr = ADDR_W'(r_len);
    assign rd_addr = ADDR_W'(i_read_index);
    assign rd_en   = in_fire && (kind == KIND_READ);

    // Line state update and result for the item in transfer
    always_comb begin
        n_len     = r_len;
        n_discard = r_discard;
        n_prefix  = r_prefix;
        n_idle    = r_idle;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        res.ev    = EV_COMPLETE;
        res.len   = '0;
        res.flag  = 1'b0;
        res.rd_ok = 1'b0;
        if (in_fire) begin
            case (kind)
                KIND_BYTE: begin
                    n_idle = '0;
                    if (i_data_byte == LF_CODE) begin
                        res_valid = 1'b1;
                        if (r_discard) begin
                            res.ev = EV_DROP;
                        end else begin
                            res.len  = pfx_len;
                            res.flag = pfx_hit;
                        end
                        n_len     = '0;
                        n_discard = 1'b0;
                        n_prefix  = '0;
                    end else if (i_data_byte != CR_CODE && !r_discard) begin
                        if (r_len < limit) begin
                            wr_en = 1'b1;
                            n_len = r_len + LEN_W'(1);
                            if (r_len < PREFIX_BYTES) begin
                                n_prefix[{r_len[1:0], 3'b000} +: 8] = i_data_byte;
                            end
                        end else begin
                            n_discard = 1'b1;
                        end
                    end
                end
                KIND_TICK: begin
                    n_idle = (r_idle < IDLE_MAX) ? r_idle + IDLE_W'(1) : r_idle;
                    if (!r_discard && r_len != '0 && n_idle >= idle_thr) begin
                        res_valid = 1'b1;
                        res.ev    = EV_FLUSH;
                        res.len   = pfx_len;
                        res.flag  = pfx_hit;
                        n_len     = '0;
                        n_prefix  = '0;
                        n_idle    = '0;
                    end
                end
                KIND_READ: begin
                    res_valid = 1'b1;
                    res.ev    = EV_READ;
                    res.rd_ok = rd_ok;
                end
                default: begin
                end
            endcase
        end
    end

    // Line store
    slr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Configuration and line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line   <= MAX_LINE_RST;
            r_idle_flush <= IDLE_FLUSH_RST;
            r_len        <= '0;
            r_discard    <= 1'b0;
            r_prefix     <= '0;
            r_idle       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_LINE) begin
                    r_max_line <= i_cfg_data;
                end else begin
                    r_idle_flush <= i_cfg_data;
                end
            end
            r_len     <= n_len;
            r_discard <= n_discard;
            r_prefix  <= n_prefix;
            r_idle    <= n_idle;
        end
    end

    // Staging register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= res_valid;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Staging register payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= res;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload, store data joins here
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_ev   <= r_s1.ev;
            r_out_len  <= r_s1.len;
            r_out_flag <= r_s1.flag;
            r_out_byte <= (r_s1.ev == EV_READ && r_s1.rd_ok) ? rd_data : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_out_ev;
    assign o_payload_length    = r_out_len;
    assign o_had_length_prefix = r_out_flag;
    assign o_read_byte         = r_out_byte;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // line never grows past the store
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= 32'(LINE_DEPTH))
        else $error("line length beyond store depth");

    // prefix bytes not yet received stay zero
    a_prefix_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len < PREFIX_BYTES) |-> ((r_prefix >> {r_len[1:0], 3'b000}) == 32'd0))
        else $error("prefix word holds bytes beyond line length");

    // newline ends the line
    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && kind == KIND_BYTE && i_data_byte == LF_CODE)
        |=> (r_len == '0 && !r_discard && r_idle == '0))
        else $error("newline did not end the line");

    // a read item is staged in the next cycle
    a_read_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_s1_valid && r_s1.ev == EV_READ))
        else $error("read item lost before staging");

    // unused result fields are zero
    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_event_res == EV_READ) ?
            (o_payload_length == '0 && !o_had_length_prefix) : (o_read_byte == '0)))
        else $error("unused result field not zero");

endmodule : serial_line_receiver
`default_nettype wire

@@ design/slr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_ram
// Generic single write port, single read port RAM with registered read data.
// Read data updates only when the read enable is high.
// ----------------------------------------------------------------------------
module slr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : slr_ram
`default_nettype wire
